@@ rtl/pe_pkg.sv @@
// ----------------------------------------------------------------------------
// pe_pkg
// Shared types and constants for the Horner polynomial evaluator.
// ----------------------------------------------------------------------------
package pe_pkg;

	localparam int NCOEF      = 8;
	localparam int DEGREE_DEF = 7;
	localparam int FRAC_BITS  = 16;
	localparam int X_W        = 32;
	localparam int COEF_W     = 32;
	localparam int ACC_W      = 48;
	localparam int PP_LO_W    = 64;
	localparam int PP_HI_W    = ACC_W - X_W + X_W;
	localparam int PROD_W     = ACC_W + X_W;
	localparam int CFG_IDX_W  = 3;

	// one value in flight between Horner steps
	typedef struct packed {
		logic signed [X_W-1:0]   x;
		logic signed [ACC_W-1:0] acc;
		logic                    ovf;
	} beat_t;

endpackage

@@ rtl/pe_step.sv @@
// ----------------------------------------------------------------------------
// pe_step
// One Horner step, acc = sat48((acc * x) >>> FRAC_BITS + coef), in three
// stages: split partial products, product sum and shift, coefficient add
// with saturation.
// ----------------------------------------------------------------------------
module pe_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pe_pkg::beat_t                  in_beat,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [pe_pkg::COEF_W-1:0] coef,
	output pe_pkg::beat_t                  out_beat,
	output logic                           out_valid,
	input  logic                           out_ready
);
	import pe_pkg::*;

	localparam int LO_W  = X_W;
	localparam int HI_W  = ACC_W - LO_W;
	localparam int SUM_W = PROD_W + 1;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [X_W-1:0]     x_s1, x_s2;
	logic                      ovf_s1, ovf_s2;
	logic signed [PP_LO_W-1:0] pplo_s1;
	logic signed [HI_W+X_W-1:0] pphi_s1;
	logic signed [PROD_W-1:0]  shf_s2;
	beat_t                     beat_s3;

	logic signed [LO_W:0]          lo_ext;
	logic signed [HI_W-1:0]        hi_part;
	logic signed [PP_LO_W:0]       pplo_full;
	logic signed [HI_W+X_W-1:0]    pphi_full;
	logic signed [PROD_W-1:0]      prod;
	logic signed [SUM_W-1:0]       sum;
	logic                          in_range;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// stage 1: 48x32 split into a 33x32 and a 16x32 product
	assign lo_ext    = $signed({1'b0, in_beat.acc[LO_W-1:0]});
	assign hi_part   = in_beat.acc[ACC_W-1:LO_W];
	assign pplo_full = lo_ext * in_beat.x;
	assign pphi_full = hi_part * in_beat.x;

	// stage 2: exact product, floor shift
	assign prod = $signed({pphi_s1, {LO_W{1'b0}}})
		+ $signed({{(PROD_W-PP_LO_W){pplo_s1[PP_LO_W-1]}}, pplo_s1});

	// stage 3: coefficient add, clamp to 48 bits
	assign sum = $signed({shf_s2[PROD_W-1], shf_s2})
		+ $signed({{(SUM_W-COEF_W){coef[COEF_W-1]}}, coef});
	assign in_range = (&sum[SUM_W-1:ACC_W-1]) || !(|sum[SUM_W-1:ACC_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			x_s1    <= in_beat.x;
			ovf_s1  <= in_beat.ovf;
			pplo_s1 <= pplo_full[PP_LO_W-1:0];
			pphi_s1 <= pphi_full;
		end
		if (rdy2) begin
			x_s2   <= x_s1;
			ovf_s2 <= ovf_s1;
			shf_s2 <= prod >>> FRAC_BITS;
		end
		if (rdy3) begin
			beat_s3.x <= x_s2;
			if (in_range) begin
				beat_s3.acc <= sum[ACC_W-1:0];
				beat_s3.ovf <= ovf_s2;
			end else begin
				beat_s3.acc <= sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
					: {1'b0, {(ACC_W-1){1'b1}}};
				beat_s3.ovf <= 1'b1;
			end
		end
	end

	assign out_beat  = beat_s3;
	assign out_valid = v_s3;

endmodule

@@ rtl/polynomial_evaluator.sv @@
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Horner evaluation of a polynomial in signed Q16.16 at a stream of points,
// giving a saturated signed Q32.16 value and an overflow flag per point.
//
//   channel  dir  fields
//   s_axis   in   tdata: x_value[31:0]
//   m_axis   out  tdata: poly_value[47:0]; tuser: overflow
//   cfg      in   cfg_index selects coef_0..coef_7, cfg_data[31:0]
//
// One beat per cycle sustained while m_axis_tready is high; three register
// stages per Horner step (split multiply, product sum/shift, add/saturate)
// plus the output register.
// Reset clears all valid bits and the coefficients.
// A stall holds each full stage; empty stages keep filling, so input is
// taken while a result waits at the output.
// ----------------------------------------------------------------------------
module polynomial_evaluator #(
	parameter int DEGREE = pe_pkg::DEGREE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [pe_pkg::X_W-1:0]           s_axis_tdata,   // x_value
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [pe_pkg::ACC_W-1:0]         m_axis_tdata,   // poly_value
	output logic                             m_axis_tuser,   // overflow
	input  logic                             cfg_we,
	input  logic [pe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pe_pkg::COEF_W-1:0]        cfg_data
);
	import pe_pkg::*;

	logic signed [COEF_W-1:0] coef_q [NCOEF];

	beat_t chain_beat  [DEGREE+1];
	logic  chain_valid [DEGREE+1];
	logic  chain_ready [DEGREE+1];

	beat_t out_beat_q;
	logic  out_valid_q;
	logic  rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOEF; i++) coef_q[i] <= '0;
		end else if (cfg_we) begin
			coef_q[cfg_index] <= $signed(cfg_data);
		end
	end

	assign chain_beat[0].x   = $signed(s_axis_tdata);
	assign chain_beat[0].acc = {{(ACC_W-COEF_W){coef_q[DEGREE][COEF_W-1]}}, coef_q[DEGREE]};
	assign chain_beat[0].ovf = 1'b0;
	assign chain_valid[0]    = s_axis_tvalid;
	assign s_axis_tready     = chain_ready[0];

	for (genvar k = 0; k < DEGREE; k++) begin : g_step
		pe_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_beat   (chain_beat[k]),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.coef      (coef_q[DEGREE-1-k]),
			.out_beat  (chain_beat[k+1]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1])
		);
	end

	assign rdy_out             = !out_valid_q || m_axis_tready;
	assign chain_ready[DEGREE] = rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= chain_valid[DEGREE];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) out_beat_q <= chain_beat[DEGREE];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_beat_q.acc;
	assign m_axis_tuser  = out_beat_q.ovf;

endmodule

@@ rtl/pe_checker.sv @@
// ----------------------------------------------------------------------------
// pe_checker
// Port-level checks for the polynomial evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pe_checker #(
	parameter int DEGREE = pe_pkg::DEGREE_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [pe_pkg::ACC_W-1:0]     m_axis_tdata,
	input logic                         m_axis_tuser
);
	import pe_pkg::*;

	localparam int DEPTH = 3 * DEGREE + 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             in_beat;
	logic             out_beat;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// beats inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_beat && !out_beat) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> cnt_q != '0)
		else $error("result without a pending input beat");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("more beats in flight than pipeline stages");

endmodule

bind polynomial_evaluator pe_checker #(.DEGREE(DEGREE)) u_pe_checker (.*);
